// ----- hw/rtl/rgbhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none

package rgbhsv_pkg;

	// Channel and result widths
	localparam int PIX_W   = 8;
	localparam int FRAC_W  = 16;
	localparam int HUE_W   = 16;
	localparam int SAT_W   = 17;
	// Hue numerator stays below six times the channel spread
	localparam int HNUM_W  = 11;
	// Sixths of a turn per full turn
	localparam int HUE_DEN_MUL = 6;
	localparam int SAT_DEN_MUL = 1;

	// Sector that holds the largest channel
	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	// Input item
	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] opacity;
	} pixel_t;

	// Result item
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [PIX_W-1:0] brightness;
		logic [PIX_W-1:0] opacity_out;
	} hsv_t;

	// Front-end output toward the dividers
	typedef struct packed {
		logic [HNUM_W-1:0] num;
		logic [PIX_W-1:0]  spread;
		logic [PIX_W-1:0]  hi;
		logic [PIX_W-1:0]  opacity;
	} prep_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgbhsv_prep.sv -----
// Front end: channel max/min, sector pick and hue numerator, two stages.
`default_nettype none

module rgbhsv_prep
	import rgbhsv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_vld,
	input  wire pixel_t pixel,
	output logic        vld_s2,
	output prep_t       prep_s2
);

	logic [PIX_W-1:0] red_s1, green_s1, blue_s1, opa_s1, hi_s1, lo_s1;
	sector_t          sect_s1;
	logic             vld_s1;

	logic             red_max, green_max;
	logic [PIX_W-1:0] hi_c, lo_c;
	sector_t          sect_c;

	// Pick the largest channel, red wins ties, then green
	always_comb begin
		red_max   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
		green_max = !red_max && (pixel.green >= pixel.blue);
		if (red_max) begin
			sect_c = SECT_RED;
			hi_c   = pixel.red;
		end else if (green_max) begin
			sect_c = SECT_GREEN;
			hi_c   = pixel.green;
		end else begin
			sect_c = SECT_BLUE;
			hi_c   = pixel.blue;
		end
		lo_c = pixel.red;
		if (pixel.green < lo_c) lo_c = pixel.green;
		if (pixel.blue < lo_c) lo_c = pixel.blue;
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		red_s1   <= pixel.red;
		green_s1 <= pixel.green;
		blue_s1  <= pixel.blue;
		opa_s1   <= pixel.opacity;
		hi_s1    <= hi_c;
		lo_s1    <= lo_c;
		sect_s1  <= sect_c;
	end

	logic [PIX_W-1:0]  spread_c;
	logic signed [11:0] rx, gx, bx, dx, d6, num_c;

	// Hue numerator in units of one sixth over the spread, wrapped into [0, 6d)
	always_comb begin
		spread_c = hi_s1 - lo_s1;
		rx = $signed({4'b0, red_s1});
		gx = $signed({4'b0, green_s1});
		bx = $signed({4'b0, blue_s1});
		dx = $signed({4'b0, spread_c});
		d6 = (dx <<< 2) + (dx <<< 1);
		unique case (sect_s1)
			SECT_RED: begin
				num_c = gx - bx;
				if (num_c < 0) num_c = num_c + d6;
			end
			SECT_GREEN: begin
				num_c = (dx <<< 1) + bx - rx;
			end
			SECT_BLUE: begin
				num_c = (dx <<< 2) + rx - gx;
			end
			default: begin
				num_c = '0;
			end
		endcase
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		prep_s2.num     <= num_c[HNUM_W-1:0];
		prep_s2.spread  <= spread_c;
		prep_s2.hi      <= hi_s1;
		prep_s2.opacity <= opa_s1;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rgbhsv_div.sv -----
// Pipelined divider: floor(num * 2^FRAC_W / (DEN_MUL * idx)) in four stages.
`default_nettype none

module rgbhsv_div
	import rgbhsv_pkg::*;
#(
	parameter int NUM_W   = HNUM_W,
	parameter int DEN_MUL = HUE_DEN_MUL,
	parameter int Q_W     = HUE_W
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [PIX_W-1:0] idx,
	input  wire logic             zero,
	output logic      [Q_W-1:0]   quot_s6
);

	localparam int K     = NUM_W + FRAC_W;
	localparam int RW    = K + 1;
	localparam int DEN_W = $clog2(DEN_MUL * ((1 << PIX_W) - 1) + 1);
	localparam int TAB_N = 1 << PIX_W;

	// Reciprocal table, floor(2^K / (DEN_MUL * i)), never above the true value
	logic [RW-1:0] recip [TAB_N];

	for (genvar i = 0; i < TAB_N; i++) begin : g_recip
		localparam longint unsigned RV =
			(64'd1 << K) / (DEN_MUL * ((i == 0) ? 1 : i));
		assign recip[i] = RW'(RV);
	end

	logic [RW-1:0]    rcp_s3;
	logic [NUM_W-1:0] num_s3, num_s4, num_s5;
	logic [DEN_W-1:0] den_s3, den_s4, den_s5;
	logic             zero_s3, zero_s4, zero_s5;
	logic [Q_W-1:0]   q_s4, q_s5;
	logic [Q_W+DEN_W-1:0] qd_s5;

	logic [NUM_W+RW-1:0] prod_c;
	logic [K-1:0]        rem_c;

	// Look up the reciprocal and form the divisor
	always_ff @(posedge clk) begin
		rcp_s3  <= recip[idx];
		num_s3  <= num;
		den_s3  <= DEN_W'(idx) * DEN_W'(DEN_MUL);
		zero_s3 <= zero;
	end

	// Estimate the quotient, at most one short of the exact value
	assign prod_c = (NUM_W + RW)'(num_s3) * (NUM_W + RW)'(rcp_s3);

	always_ff @(posedge clk) begin
		q_s4    <= Q_W'(prod_c >> NUM_W);
		num_s4  <= num_s3;
		den_s4  <= den_s3;
		zero_s4 <= zero_s3;
	end

	// Multiply back for the remainder
	always_ff @(posedge clk) begin
		qd_s5   <= (Q_W + DEN_W)'(q_s4) * (Q_W + DEN_W)'(den_s4);
		q_s5    <= q_s4;
		num_s5  <= num_s4;
		den_s5  <= den_s4;
		zero_s5 <= zero_s4;
	end

	// Correct the estimate by one where the remainder reaches the divisor
	assign rem_c = {num_s5, {FRAC_W{1'b0}}} - K'(qd_s5);

	always_ff @(posedge clk) begin
		if (zero_s5) begin
			quot_s6 <= '0;
		end else if (rem_c >= K'(den_s5)) begin
			quot_s6 <= q_s5 + Q_W'(1);
		end else begin
			quot_s6 <= q_s5;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_pixel.sv -----
// RGB to HSV pixel converter, top level: one pixel in and one result out per clock.
// One item is taken in every clock cycle: busy stays low, so start alone launches a pixel.
// The result appears at the output for one cycle with done high; results cannot be held
// off and leave in the order the pixels came in. Two front-end stages find the largest and
// smallest channel and the hue numerator; two four-stage reciprocal dividers (table lookup,
// multiply, multiply back, one-step correction) form hue and saturation. Hue is a fraction of
// a full turn in 0.16 format, saturation in 1.16 format, brightness is the largest channel.
`default_nettype none

module rgb_to_hsv_pixel
	import rgbhsv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire pixel_t pixel,
	output logic        done,
	output hsv_t        result
);

	logic  vld_s2;
	prep_t prep_s2;

	logic vld_s3, vld_s4, vld_s5, vld_s6;
	logic [PIX_W-1:0] hi_s3, hi_s4, hi_s5, hi_s6;
	logic [PIX_W-1:0] opa_s3, opa_s4, opa_s5, opa_s6;
	logic [HUE_W-1:0] hue_s6;
	logic [SAT_W-1:0] sat_s6;

	// The pipeline never stalls
	assign busy = 1'b0;

	rgbhsv_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.pixel   (pixel),
		.vld_s2  (vld_s2),
		.prep_s2 (prep_s2)
	);

	rgbhsv_div #(
		.NUM_W   (HNUM_W),
		.DEN_MUL (HUE_DEN_MUL),
		.Q_W     (HUE_W)
	) u_hue_div (
		.clk     (clk),
		.num     (prep_s2.num),
		.idx     (prep_s2.spread),
		.zero    (prep_s2.spread == '0),
		.quot_s6 (hue_s6)
	);

	rgbhsv_div #(
		.NUM_W   (PIX_W),
		.DEN_MUL (SAT_DEN_MUL),
		.Q_W     (SAT_W)
	) u_sat_div (
		.clk     (clk),
		.num     (prep_s2.spread),
		.idx     (prep_s2.hi),
		.zero    (prep_s2.hi == '0),
		.quot_s6 (sat_s6)
	);

	// Advance valid alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Carry brightness and alpha to the output stage
	always_ff @(posedge clk) begin
		hi_s3  <= prep_s2.hi;
		hi_s4  <= hi_s3;
		hi_s5  <= hi_s4;
		hi_s6  <= hi_s5;
		opa_s3 <= prep_s2.opacity;
		opa_s4 <= opa_s3;
		opa_s5 <= opa_s4;
		opa_s6 <= opa_s5;
	end

	// Drive the result item
	assign done               = vld_s6;
	assign result.hue         = hue_s6;
	assign result.saturation  = sat_s6;
	assign result.brightness  = hi_s6;
	assign result.opacity_out = opa_s6;

endmodule

`default_nettype wire

// ----- tb/rgb_to_hsv_pixel_tb.sv -----
// Self-checking testbench for the RGB to HSV pixel converter, with random gaps on input.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb
	import rgbhsv_pkg::*;
();

	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 10;
	localparam int RAND_ITEMS  = 1100;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_CYCLES  = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int Q16_ONE     = 1 << FRAC_W;

	// One pending pixel, the idle cycles after it, and whether to drain the pipe first
	typedef struct {
		pixel_t px;
		int     gap_after;
		bit     drain_first;
	} pixel_job_t;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	pixel_t pixel  = '0;
	logic   busy;
	logic   done;
	hsv_t   result;

	pixel_job_t pixel_job_q[$];
	hsv_t       hsv_expect_q[$];
	int         in_flight     = 0;
	int         idle_left     = 0;
	int         pixels_taken  = 0;
	int         hsv_checked   = 0;
	int         hsv_mismatches = 0;
	int         drain_pauses  = 0;
	int         directed_cnt  = 0;
	int         cycle_cnt     = 0;

	rgb_to_hsv_pixel dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.pixel (pixel),
		.done  (done),
		.result(result)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Predict the HSV item for one pixel with exact integer arithmetic
	function automatic hsv_t convert_to_hsv(pixel_t px);
		int      r, g, b, hi, lo, spread, num;
		sector_t sect;
		hsv_t    res;
		r = int'(px.red);
		g = int'(px.green);
		b = int'(px.blue);
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		spread = hi - lo;
		res = '0;
		// red wins ties, then green
		if (hi == r)
			sect = SECT_RED;
		else if (hi == g)
			sect = SECT_GREEN;
		else
			sect = SECT_BLUE;
		if (spread != 0) begin
			case (sect)
				SECT_RED:   num = g - b;
				SECT_GREEN: num = 2 * spread + b - r;
				default:    num = 4 * spread + r - g;
			endcase
			// wrap into one full turn
			if (num < 0)
				num += HUE_DEN_MUL * spread;
			if (num >= HUE_DEN_MUL * spread)
				num -= HUE_DEN_MUL * spread;
			res.hue = HUE_W'((num * Q16_ONE) / (HUE_DEN_MUL * spread));
		end
		if (hi != 0)
			res.saturation = SAT_W'((spread * Q16_ONE) / hi);
		res.brightness  = hi[PIX_W-1:0];
		res.opacity_out = px.opacity;
		return res;
	endfunction

	// Queue one pixel for the driver
	task automatic add_pixel(int r, int g, int b, int a, int gap, bit drain);
		pixel_job_t job;
		job.px.red      = r[PIX_W-1:0];
		job.px.green    = g[PIX_W-1:0];
		job.px.blue     = b[PIX_W-1:0];
		job.px.opacity  = a[PIX_W-1:0];
		job.gap_after   = gap;
		job.drain_first = drain;
		pixel_job_q.push_back(job);
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Pick a channel value near a base, clamped to the channel range
	function automatic int near_value(int base);
		int v;
		v = base + $urandom_range(0, 6) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v;
	endfunction

	// Drive items from the pending queue, hold while busy, idle between items
	always @(posedge clk or negedge arst_n) begin
		pixel_job_t job;
		if (!arst_n) begin
			start     <= 1'b0;
			idle_left <= 0;
		end else if (start && busy) begin
			// hold the item until taken
		end else if (start) begin
			// item taken this edge: chain the next one only when no gap or drain is due
			if (idle_left == 0 && pixel_job_q.size() != 0 && !pixel_job_q[0].drain_first) begin
				job = pixel_job_q.pop_front();
				pixel     <= job.px;
				idle_left <= job.gap_after;
			end else begin
				start <= 1'b0;
			end
		end else if (idle_left != 0) begin
			idle_left <= idle_left - 1;
		end else if (pixel_job_q.size() != 0 &&
			(!pixel_job_q[0].drain_first || in_flight == 0)) begin
			job = pixel_job_q.pop_front();
			if (job.drain_first)
				drain_pauses++;
			pixel     <= job.px;
			start     <= 1'b1;
			idle_left <= job.gap_after;
		end
	end

	// Check each result against the oldest expectation, then record the item taken
	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			in_flight <= 0;
		end else begin
			if (done) begin
				hsv_checked++;
				if (hsv_expect_q.size() == 0) begin
					hsv_mismatches++;
					if (hsv_mismatches <= MAX_REPORTS)
						$display("unexpected result hue=%0d sat=%0d val=%0d a=%0d",
							result.hue, result.saturation, result.brightness,
							result.opacity_out);
				end else begin
					want = hsv_expect_q.pop_front();
					if (result.hue !== want.hue || result.saturation !== want.saturation ||
						result.brightness !== want.brightness ||
						result.opacity_out !== want.opacity_out) begin
						hsv_mismatches++;
						if (hsv_mismatches <= MAX_REPORTS)
							$display({"mismatch: expected hue=%0d sat=%0d val=%0d a=%0d,",
								" got hue=%0d sat=%0d val=%0d a=%0d"},
								want.hue, want.saturation, want.brightness,
								want.opacity_out, result.hue, result.saturation,
								result.brightness, result.opacity_out);
					end
				end
			end
			if (start && !busy) begin
				hsv_expect_q.push_back(convert_to_hsv(pixel));
				pixels_taken++;
			end
			in_flight <= hsv_expect_q.size();
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int  kind, r, g, b, a, base;
		bit  burst;
		// Directed pixels: grey, black, ties, sector edges, wrapped red hue, bit patterns
		add_pixel(0, 0, 0, 0, 0, 1'b0);
		add_pixel(255, 255, 255, 255, 0, 1'b0);
		add_pixel(128, 128, 128, 17, 1, 1'b0);
		add_pixel(255, 0, 0, 255, 0, 1'b0);
		add_pixel(0, 255, 0, 0, 0, 1'b0);
		add_pixel(0, 0, 255, 128, 2, 1'b0);
		add_pixel(255, 255, 0, 1, 0, 1'b0);
		add_pixel(0, 255, 255, 254, 0, 1'b0);
		add_pixel(255, 0, 255, 64, 0, 1'b0);
		add_pixel(255, 0, 10, 3, 1, 1'b0);
		add_pixel(255, 0, 1, 200, 0, 1'b0);
		add_pixel(255, 10, 0, 99, 0, 1'b0);
		add_pixel(1, 0, 0, 0, 0, 1'b0);
		add_pixel(0, 0, 1, 255, 0, 1'b0);
		add_pixel(0, 1, 255, 7, 3, 1'b0);
		add_pixel(254, 255, 0, 170, 0, 1'b0);
		add_pixel(8'hAA, 8'h55, 8'hFF, 8'h55, 0, 1'b0);
		add_pixel(8'h55, 8'hAA, 8'h00, 8'hAA, 0, 1'b0);
		add_pixel(1, 1, 0, 8'h80, 0, 1'b0);
		add_pixel(255, 254, 255, 8'h7F, 0, 1'b0);
		directed_cnt = pixel_job_q.size();

		// Random pixels: mostly free channels, plus ties, greys, narrow spreads, extremes
		burst = 1'b0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			r = $urandom_range(0, 255);
			g = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			a = $urandom_range(0, 255);
			case (kind)
				6: begin
					// tie two channels
					case ($urandom_range(0, 2))
						0: g = r;
						1: b = g;
						default: b = r;
					endcase
				end
				7: begin
					g = r;
					b = r;
				end
				8: begin
					base = $urandom_range(0, 255);
					r = near_value(base);
					g = near_value(base);
					b = near_value(base);
				end
				9: begin
					r = $urandom_range(0, 1) * 255;
					g = $urandom_range(0, 1) * 255;
					b = $urandom_range(0, 1) * 255;
				end
				default: ;
			endcase
			add_pixel(r, g, b, a, burst ? 0 : pick_gap(),
				(i == 0) || ($urandom_range(0, 149) == 0));
		end

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last item to be taken and its result to arrive
		@(negedge clk);
		while (pixel_job_q.size() != 0 || start || in_flight != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (hsv_expect_q.size() != 0) begin
			$display("%0d results never arrived", hsv_expect_q.size());
			hsv_mismatches += hsv_expect_q.size();
		end
		$display("Converted %0d pixels (%0d directed, rest random, %0d drain pauses),",
			pixels_taken, directed_cnt, drain_pauses);
		$display("checked %0d results, %0d failures", hsv_checked, hsv_mismatches);
		if (hsv_mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
